@@ rtl/core/b58_pkg.sv @@
// Shared constants and the alphabet lookup for the base58 encoder.
`timescale 1ns / 1ps

package b58_pkg;

  // Input string and result limits
  localparam int MAX_BYTES    = 32;
  localparam int MAX_DIGITS   = 44;
  localparam int RESULT_LIMIT = 44;

  // Accumulator and digit sizes
  localparam int ACC_W   = 256;
  localparam int RADIX   = 58;
  localparam int DIG_W   = $clog2(RADIX);
  localparam int BIT_CW  = $clog2(ACC_W);
  localparam int BYTE_CW = $clog2(MAX_BYTES + 1);
  localparam int DIG_AW  = $clog2(MAX_DIGITS);
  localparam int DIG_CW  = $clog2(MAX_DIGITS + 1);
  localparam int OUT_CW  = $clog2(RESULT_LIMIT + 1);

  localparam logic [6:0] ONE_CHAR = 7'h31;

  // First character sits in the top byte
  localparam logic [RADIX*8-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // Map a digit to its ASCII character, clamping out-of-range codes to the top one
  function automatic logic [6:0] digit_char(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] dc;
    logic [DIG_W-1:0] idx;
    dc  = (d > DIG_W'(RADIX - 1)) ? DIG_W'(RADIX - 1) : d;
    idx = DIG_W'(RADIX - 1) - dc;
    return ALPHABET[{idx, 3'b000} +: 7];
  endfunction

endpackage

@@ rtl/core/b58_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module b58_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/base58_encoder_top.sv @@
// Base58 encoder top level: byte loader, bit-serial divide by 58, character output.
// Flow: each byte is shifted into the 256-bit accumulator; if any byte was non-zero, the final byte
//   starts a bit-serial long division that yields one base58 digit per pass (up to 44 digits),
//   each pass a one-bit remainder update per bit of the 256-bit accumulator shift register.
// Output: the leading '1' characters first, then each digit after a digit buffer RAM read.
// Results come one per strobe cycle and the receiver cannot stall them.
// Reset: asynchronous active-low reset clears control state; the digit buffer is not cleared.
`timescale 1ns / 1ps

module base58_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  output logic       res_valid_o,
  output logic [6:0] code_char_o,
  output logic       last_char_o,
  output logic       too_long_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ONES,
    ST_RD,
    ST_DIG
  } state_e;

  state_e state_q;

  logic [b58_pkg::ACC_W-1:0]   acc_q;
  logic [b58_pkg::BYTE_CW-1:0] lzc_q;
  logic                        seen_q;
  logic [b58_pkg::BYTE_CW-1:0] cnt_q;
  logic                        ovf_q;
  logic [b58_pkg::BIT_CW-1:0]  bit_cnt_q;
  logic [b58_pkg::DIG_W-1:0]   rem_q;
  logic                        qnz_q;
  logic [b58_pkg::DIG_CW-1:0]  nd_q;
  logic [b58_pkg::BYTE_CW-1:0] ones_left_q;
  logic [b58_pkg::DIG_AW-1:0]  dig_idx_q;
  logic [b58_pkg::OUT_CW-1:0]  out_cnt_q;

  logic       valid_q;
  logic [6:0] code_q;
  logic       last_q;
  logic       tl_q;

  // Load path: values after taking the current word
  logic [b58_pkg::BYTE_CW-1:0] lzc_d;
  logic                        seen_d;
  logic [b58_pkg::BYTE_CW-1:0] cnt_d;
  logic                        ovf_d;
  logic                        load_en;

  always_comb begin
    lzc_d   = lzc_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    load_en = 1'b0;
    if (cnt_q >= b58_pkg::BYTE_CW'(b58_pkg::MAX_BYTES)) begin
      ovf_d = 1'b1;
    end else if (!ovf_q) begin
      load_en = 1'b1;
      if (data_byte_i == 8'h00 && !seen_q) begin
        lzc_d = lzc_q + 1'b1;
      end
      if (data_byte_i != 8'h00) begin
        seen_d = 1'b1;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Bit-serial divide step: remainder doubles and takes the accumulator MSB
  logic [b58_pkg::DIG_W:0]   trial;
  logic [b58_pkg::DIG_W:0]   trial_sub;
  logic                      q_bit;
  logic [b58_pkg::DIG_W-1:0] rem_d;
  logic                      qnz_d;
  logic                      pass_end;
  logic                      div_stop;

  assign trial     = {rem_q, acc_q[b58_pkg::ACC_W-1]};
  assign trial_sub = trial - (b58_pkg::DIG_W + 1)'(b58_pkg::RADIX);
  assign q_bit     = trial >= (b58_pkg::DIG_W + 1)'(b58_pkg::RADIX);
  assign rem_d     = q_bit ? trial_sub[b58_pkg::DIG_W-1:0] : trial[b58_pkg::DIG_W-1:0];
  assign qnz_d     = qnz_q | q_bit;
  assign pass_end  = (bit_cnt_q == b58_pkg::BIT_CW'(b58_pkg::ACC_W - 1));
  assign div_stop  = !qnz_d || (nd_q + 1'b1 == b58_pkg::DIG_CW'(b58_pkg::MAX_DIGITS));

  // Digit buffer
  logic                      ram_we;
  logic [b58_pkg::DIG_W-1:0] ram_rdata;

  assign ram_we = (state_q == ST_DIV) && pass_end;

  b58_ram #(
    .WIDTH(b58_pkg::DIG_W),
    .DEPTH(b58_pkg::MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(nd_q[b58_pkg::DIG_AW-1:0]),
    .wdata_i(rem_d),
    .raddr_i(dig_idx_q),
    .rdata_o(ram_rdata)
  );

  // Final-result checks for each output phase
  logic out_at_limit;
  logic ones_final;
  logic dig_final;

  assign out_at_limit = (out_cnt_q == b58_pkg::OUT_CW'(b58_pkg::RESULT_LIMIT - 1));
  assign ones_final   = ((ones_left_q == b58_pkg::BYTE_CW'(1)) && (nd_q == '0)) || out_at_limit;
  assign dig_final    = (dig_idx_q == '0) || out_at_limit;

  // Control state machine, datapath registers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      lzc_q       <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      qnz_q       <= 1'b0;
      nd_q        <= '0;
      ones_left_q <= '0;
      dig_idx_q   <= '0;
      out_cnt_q   <= '0;
      valid_q     <= 1'b0;
      code_q      <= '0;
      last_q      <= 1'b0;
      tl_q        <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            if (load_en) begin
              acc_q <= {acc_q[b58_pkg::ACC_W-9:0], data_byte_i};
            end
            lzc_q  <= lzc_d;
            seen_q <= seen_d;
            cnt_q  <= cnt_d;
            ovf_q  <= ovf_d;
            if (is_last_i) begin
              lzc_q       <= '0;
              seen_q      <= 1'b0;
              cnt_q       <= '0;
              ovf_q       <= 1'b0;
              ones_left_q <= lzc_d;
              nd_q        <= '0;
              out_cnt_q   <= '0;
              bit_cnt_q   <= '0;
              rem_q       <= '0;
              qnz_q       <= 1'b0;
              if (ovf_d) begin
                acc_q   <= '0;
                valid_q <= 1'b1;
                code_q  <= '0;
                last_q  <= 1'b1;
                tl_q    <= 1'b1;
              end else if (seen_d) begin
                state_q <= ST_DIV;
              end else begin
                state_q <= ST_ONES;
              end
            end
          end
        end
        ST_DIV: begin
          acc_q     <= {acc_q[b58_pkg::ACC_W-2:0], q_bit};
          rem_q     <= rem_d;
          qnz_q     <= qnz_d;
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (pass_end) begin
            nd_q      <= nd_q + 1'b1;
            rem_q     <= '0;
            qnz_q     <= 1'b0;
            bit_cnt_q <= '0;
            if (div_stop) begin
              acc_q     <= '0;
              dig_idx_q <= nd_q[b58_pkg::DIG_AW-1:0];
              state_q   <= (ones_left_q != '0) ? ST_ONES : ST_RD;
            end
          end
        end
        ST_ONES: begin
          valid_q     <= 1'b1;
          code_q      <= b58_pkg::ONE_CHAR;
          last_q      <= ones_final;
          tl_q        <= 1'b0;
          ones_left_q <= ones_left_q - 1'b1;
          out_cnt_q   <= out_cnt_q + 1'b1;
          if (ones_final) begin
            state_q <= ST_IDLE;
          end else if (ones_left_q == b58_pkg::BYTE_CW'(1)) begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_DIG;
        end
        ST_DIG: begin
          valid_q   <= 1'b1;
          code_q    <= b58_pkg::digit_char(ram_rdata);
          last_q    <= dig_final;
          tl_q      <= 1'b0;
          out_cnt_q <= out_cnt_q + 1'b1;
          if (dig_final) begin
            state_q <= ST_IDLE;
          end else begin
            dig_idx_q <= dig_idx_q - 1'b1;
            state_q   <= ST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = valid_q;
  assign code_char_o = code_q;
  assign last_char_o = last_q;
  assign too_long_o  = tl_q;

`ifndef SYNTHESIS
  // A too-long result is a single final word with an empty character
  a_too_long_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && tl_q) |-> (last_q && code_q == '0))
    else $error("too-long result not final or not empty");

  // A non-final character means more output is still pending
  a_more_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q) |-> busy_o)
    else $error("non-final character with block idle");

  // Division remainder stays below the radix
  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < b58_pkg::DIG_W'(b58_pkg::RADIX)))
    else $error("remainder out of range");

  // Digit count and output count stay within their limits
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nd_q <= b58_pkg::DIG_CW'(b58_pkg::MAX_DIGITS)) &&
    (out_cnt_q <= b58_pkg::OUT_CW'(b58_pkg::RESULT_LIMIT)))
    else $error("digit or output count past limit");

  // No character is emitted during the division
  a_quiet_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (!valid_q || tl_q == 1'b0) && ($past(state_q) != ST_DIV || !valid_q))
    else $error("output strobe during division");
`endif

endmodule
